FILE: sv/ihex_pkg.sv
`default_nettype none

package ihex_pkg;

   // record text codes
   localparam logic [7:0] COLON        = 8'h3A;
   localparam logic [7:0] TYPE_DATA    = 8'h00;
   localparam logic [7:0] TYPE_EOF     = 8'h01;
   localparam logic [7:0] TYPE_EXT_LIN = 8'h04;

   // configuration port
   localparam int         CSR_ADDR_W       = 3;
   localparam logic       CSR_IDX_FLASH    = 1'b0;
   localparam logic       CSR_IDX_BUF_SIZE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_MALFORMED = 3'd1,
      ST_CHECKSUM  = 3'd2,
      ST_RANGE     = 3'd3,
      ST_TOO_LONG  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_W_ADDR,
      S_W_CHECK,
      S_STATUS
   } ctrl_state_type;

   typedef struct packed {
      logic take_char;
      logic new_image;
      logic check;
      logic addr_step;
      logic flag_range;
      logic emit_write;
      logic emit_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic loop_go;
      logic out_range;
      logic last_write;
      logic out_free;
   } dp_stat_type;

   typedef struct packed {
      logic        is_write;
      logic [31:0] buffer_offset;
      logic [7:0]  data_byte;
      logic [2:0]  status;
      logic [5:0]  bytes_written;
      logic [31:0] lowest_address;
      logic [31:0] highest_address;
      logic        last;
   } rsp_word_type;

   // {valid, nibble} of one ascii hex digit, either case
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/ihex_if.sv
`default_nettype none

interface ihex_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] character_code;
   logic       end_of_record;

   modport source (output valid, output mode, output character_code,
                   output end_of_record, input ready);
   modport sink   (input valid, input mode, input character_code,
                   input end_of_record, output ready);
endinterface

interface ihex_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_write;
   logic [31:0] buffer_offset;
   logic [7:0]  data_byte;
   logic [2:0]  status;
   logic [5:0]  bytes_written;
   logic [31:0] lowest_address;
   logic [31:0] highest_address;
   logic        last;

   modport source (output valid, output is_write, output buffer_offset,
                   output data_byte, output status, output bytes_written,
                   output lowest_address, output highest_address, output last,
                   input ready);
   modport sink   (input valid, input is_write, input buffer_offset,
                   input data_byte, input status, input bytes_written,
                   input lowest_address, input highest_address, input last,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/ihex_ctrl.sv
`default_nettype none

module ihex_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    req_mode,
   input  wire                    req_end_of_record,
   output logic                   req_ready,
   input  ihex_pkg::dp_stat_type  stat,
   output ihex_pkg::ctrl_cmd_type cmd
);

   ihex_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ihex_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ihex_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode) begin
                  cmd.new_image = 1'b1;
               end else begin
                  cmd.take_char = 1'b1;
                  if (req_end_of_record) begin
                     state_in = ihex_pkg::S_CHECK;
                  end
               end
            end
         end
         ihex_pkg::S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.loop_go ? ihex_pkg::S_W_ADDR : ihex_pkg::S_STATUS;
         end
         ihex_pkg::S_W_ADDR: begin
            cmd.addr_step = 1'b1;
            state_in      = ihex_pkg::S_W_CHECK;
         end
         ihex_pkg::S_W_CHECK: begin
            if (stat.out_range) begin
               cmd.flag_range = 1'b1;
               state_in       = ihex_pkg::S_STATUS;
            end else if (stat.out_free) begin
               cmd.emit_write = 1'b1;
               state_in = stat.last_write ? ihex_pkg::S_STATUS : ihex_pkg::S_W_ADDR;
            end
         end
         ihex_pkg::S_STATUS: begin
            if (stat.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = ihex_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ihex_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/ihex_dp.sv
`default_nettype none

module ihex_dp #(
   parameter int MAX_DATA = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  ihex_pkg::ctrl_cmd_type cmd,
   output ihex_pkg::dp_stat_type  stat,
   input  wire [7:0]              character_code,
   input  wire [31:0]             flash_base,
   input  wire [31:0]             buffer_size,
   input  wire                    rsp_ready,
   output logic                   rsp_valid,
   output ihex_pkg::rsp_word_type rsp_word
);

   localparam int STORE_DEPTH = (MAX_DATA < 2) ? 2 : MAX_DATA;
   localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic [7:0]  pos_ff,    pos_in;
   logic [3:0]  hold_ff,   hold_in;
   logic [7:0]  count_ff,  count_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0]  type_ff,   type_in;
   logic [7:0]  sum_ff,    sum_in;
   ihex_pkg::status_type err_ff, err_in, final_code;
   logic [15:0] ext_ff,    ext_in;
   logic [31:0] lo_ff,     lo_in;
   logic [31:0] hi_ff,     hi_in;
   logic [15:0] shadow_ff, shadow_in;
   logic [5:0]  i_ff,      i_in;
   logic [31:0] addr_ff,   addr_in;
   logic [31:0] off_ff,    off_in;
   logic [7:0]  rd_ff;
   logic        out_valid_ff, out_valid_in;
   ihex_pkg::rsp_word_type out_word_ff, out_word_in;

   logic [7:0]  data_store [STORE_DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   logic [7:0]  pos_m1;
   logic [6:0]  idx;
   logic [6:0]  store_idx;
   logic [6:0]  got;
   logic [8:0]  needed;
   logic [4:0]  hexv;
   logic [7:0]  byte_val;
   logic        malformed;
   logic        out_free;

   assign pos_m1    = pos_ff - 8'd1;
   assign idx       = pos_m1[7:1];
   assign store_idx = idx - 7'd4;
   assign got       = (pos_ff != 8'd0) ? pos_m1[7:1] : 7'd0;
   assign hexv      = ihex_pkg::hex_nibble(character_code);
   assign byte_val  = {hold_ff, hexv[3:0]};
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      if (type_ff == ihex_pkg::TYPE_EOF) begin
         needed = 9'd5;
      end else if (type_ff == ihex_pkg::TYPE_EXT_LIN) begin
         needed = 9'd7;
      end else begin
         needed = 9'd5 + {1'b0, count_ff};
      end
   end

   // record verdict once the final character is in
   assign malformed = (pos_ff < 8'd9) || ({2'b00, got} < needed);

   always_comb begin
      if (err_ff != ihex_pkg::ST_OK) begin
         final_code = err_ff;
      end else if (malformed) begin
         final_code = ihex_pkg::ST_MALFORMED;
      end else if (sum_ff != 8'd0) begin
         final_code = ihex_pkg::ST_CHECKSUM;
      end else begin
         final_code = ihex_pkg::ST_OK;
      end
   end

   assign stat.loop_go    = (final_code == ihex_pkg::ST_OK) &&
                            (type_ff == ihex_pkg::TYPE_DATA) && (count_ff != 8'd0);
   assign stat.out_range  = off_ff >= buffer_size;
   assign stat.last_write = ({2'b00, i_ff} + 8'd1) == count_ff;
   assign stat.out_free   = out_free;

   always_comb begin
      pos_in    = pos_ff;
      hold_in   = hold_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      type_in   = type_ff;
      sum_in    = sum_ff;
      err_in    = err_ff;
      ext_in    = ext_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      shadow_in = shadow_ff;
      i_in      = i_ff;
      addr_in   = addr_ff;
      off_in    = off_ff;
      mem_we    = 1'b0;
      mem_waddr = store_idx[AW-1:0];
      mem_wdata = byte_val;

      if (cmd.new_image) begin
         pos_in    = '0;
         hold_in   = '0;
         count_in  = '0;
         offset_in = '0;
         type_in   = '0;
         sum_in    = '0;
         err_in    = ihex_pkg::ST_OK;
         ext_in    = '0;
         lo_in     = '1;
         hi_in     = '0;
      end else if (cmd.take_char) begin
         if (pos_ff != 8'hFF) begin
            pos_in = pos_ff + 8'd1;
         end
         if (err_ff == ihex_pkg::ST_OK) begin
            if (pos_ff == 8'd0) begin
               if (character_code != ihex_pkg::COLON) begin
                  err_in = ihex_pkg::ST_MALFORMED;
               end
            end else if (!(idx >= 7'd4 && {2'b00, idx} >= needed)) begin
               if (!hexv[4]) begin
                  err_in = ihex_pkg::ST_MALFORMED;
               end else if (!pos_m1[0]) begin
                  hold_in = hexv[3:0];
               end else begin
                  sum_in = sum_ff + byte_val;
                  unique case (idx)
                     7'd0: count_in = byte_val;
                     7'd1: offset_in = {byte_val, offset_ff[7:0]};
                     7'd2: offset_in = {offset_ff[15:8], byte_val};
                     7'd3: begin
                        type_in = byte_val;
                        if (byte_val != ihex_pkg::TYPE_EOF &&
                            byte_val != ihex_pkg::TYPE_EXT_LIN &&
                            count_ff > 8'(MAX_DATA)) begin
                           err_in = ihex_pkg::ST_TOO_LONG;
                        end
                     end
                     default: begin
                        if (store_idx < 7'(STORE_DEPTH)) begin
                           mem_we = 1'b1;
                        end
                        // first two data bytes kept for the extended base
                        if (idx == 7'd4) begin
                           shadow_in = {byte_val, shadow_ff[7:0]};
                        end else if (idx == 7'd5) begin
                           shadow_in = {shadow_ff[15:8], byte_val};
                        end
                     end
                  endcase
               end
            end
         end
      end else if (cmd.check) begin
         err_in  = final_code;
         i_in    = '0;
         addr_in = {ext_ff, offset_ff};
         if (final_code == ihex_pkg::ST_OK && type_ff == ihex_pkg::TYPE_EXT_LIN) begin
            ext_in = shadow_ff;
         end
      end else if (cmd.addr_step) begin
         if (addr_ff < lo_ff) begin
            lo_in = addr_ff;
         end
         if (addr_ff > hi_ff) begin
            hi_in = addr_ff;
         end
         off_in = addr_ff - flash_base;
      end else if (cmd.flag_range) begin
         err_in = ihex_pkg::ST_RANGE;
      end else if (cmd.emit_write) begin
         i_in    = i_ff + 6'd1;
         addr_in = addr_ff + 32'd1;
      end else if (cmd.emit_status) begin
         pos_in    = '0;
         hold_in   = '0;
         count_in  = '0;
         offset_in = '0;
         type_in   = '0;
         sum_in    = '0;
         err_in    = ihex_pkg::ST_OK;
      end
   end

   always_comb begin
      out_word_in  = out_word_ff;
      out_valid_in = rsp_ready ? 1'b0 : out_valid_ff;
      if (cmd.emit_write) begin
         out_word_in               = '0;
         out_word_in.is_write      = 1'b1;
         out_word_in.buffer_offset = off_ff;
         out_word_in.data_byte     = rd_ff;
         out_valid_in              = 1'b1;
      end else if (cmd.emit_status) begin
         out_word_in                 = '0;
         out_word_in.status          = err_ff;
         out_word_in.bytes_written   = i_ff;
         out_word_in.lowest_address  = lo_ff;
         out_word_in.highest_address = hi_ff;
         out_word_in.last            = 1'b1;
         out_valid_in                = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hold_ff      <= '0;
         count_ff     <= '0;
         offset_ff    <= '0;
         type_ff      <= '0;
         sum_ff       <= '0;
         err_ff       <= ihex_pkg::ST_OK;
         ext_ff       <= '0;
         lo_ff        <= '1;
         hi_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         hold_ff      <= hold_in;
         count_ff     <= count_in;
         offset_ff    <= offset_in;
         type_ff      <= type_in;
         sum_ff       <= sum_in;
         err_ff       <= err_in;
         ext_ff       <= ext_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shadow_ff   <= shadow_in;
      i_ff        <= i_in;
      addr_ff     <= addr_in;
      off_ff      <= off_in;
      out_word_ff <= out_word_in;
   end

   // record data store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         data_store[mem_waddr] <= mem_wdata;
      end
      if (cmd.addr_step) begin
         rd_ff <= data_store[i_ff[AW-1:0]];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

`default_nettype wire

FILE: sv/intel_hex_record_parser.sv
`default_nettype none

// intel hex record parser: feed a record one character per word (mode 0), with
// end_of_record set on its final character; mode 1 starts a new image and
// clears the extended base and the seen address range. characters are taken
// back to back while no record is finishing. on the final character the block
// finishes the record: it settles the verdict, then for each data byte the data
// store's registered read and the address subtract against flash_base share a
// step before the range check and the write; then comes the status word. a
// byte outside the buffer ends the loop with a range status. write and status
// words wait while the result side stalls. req ready is low while a record
// finishes; a finished word waiting in the output register does not hold up
// the next characters. flash_base sits at byte address 0 and buffer_size at 4
// of the apb-style register port, which must only be written while idle.
module intel_hex_record_parser #(
   parameter int MAX_DATA = 32
) (
   input  wire                                clock,
   input  wire                                reset,
   ihex_req_if.sink                           req_bus,
   ihex_rsp_if.source                         rsp_bus,
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire [ihex_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire [31:0]                         pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   // configuration registers
   logic [31:0] flash_base_ff;
   logic [31:0] buffer_size_ff;
   logic        csr_write;

   ihex_pkg::ctrl_cmd_type cmd;
   ihex_pkg::dp_stat_type  stat;
   ihex_pkg::rsp_word_type rsp_word;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   // register select on the word address bit
   always_ff @(posedge clock) begin
      if (reset) begin
         flash_base_ff  <= '0;
         buffer_size_ff <= '0;
      end else if (csr_write) begin
         unique case (paddr[2])
            ihex_pkg::CSR_IDX_FLASH:    flash_base_ff  <= pwdata;
            ihex_pkg::CSR_IDX_BUF_SIZE: buffer_size_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         ihex_pkg::CSR_IDX_FLASH:    prdata = flash_base_ff;
         ihex_pkg::CSR_IDX_BUF_SIZE: prdata = buffer_size_ff;
         default:                    prdata = '0;
      endcase
   end

   // sequencer: character intake, verdict, write loop, status word
   ihex_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_mode          (req_bus.mode),
      .req_end_of_record (req_bus.end_of_record),
      .req_ready         (req_bus.ready),
      .stat              (stat),
      .cmd               (cmd)
   );

   // record fields, checksum, data store, address range and output register
   ihex_dp #(
      .MAX_DATA (MAX_DATA)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .character_code (req_bus.character_code),
      .flash_base     (flash_base_ff),
      .buffer_size    (buffer_size_ff),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_word       (rsp_word)
   );

   // result word onto the channel
   assign rsp_bus.is_write        = rsp_word.is_write;
   assign rsp_bus.buffer_offset   = rsp_word.buffer_offset;
   assign rsp_bus.data_byte       = rsp_word.data_byte;
   assign rsp_bus.status          = rsp_word.status;
   assign rsp_bus.bytes_written   = rsp_word.bytes_written;
   assign rsp_bus.lowest_address  = rsp_word.lowest_address;
   assign rsp_bus.highest_address = rsp_word.highest_address;
   assign rsp_bus.last            = rsp_word.last;

endmodule

`default_nettype wire
